/* design/fpps_pkg.sv */
// ----------------------------------------------------------------------------
// Flash page program sequencer package
// Shared constants, result codes and the job descriptor passed from the
// front end to the result expander.
// ----------------------------------------------------------------------------
package fpps_pkg;

   localparam int ADDRESS_BITS_DEFAULT = 19;
   localparam int MEM_SIZE_BITS        = 20;
   localparam int POLL_LIMIT_BITS      = 11;
   localparam int CSR_INDEX_BITS       = 2;
   localparam int CSR_DATA_BITS        = MEM_SIZE_BITS;
   localparam int DATA_BITS            = 8;
   localparam int PAGE_BITS            = 8;

   localparam logic [MEM_SIZE_BITS-1:0] SIZE_SMALL_MAX  = MEM_SIZE_BITS'(65536);
   localparam logic [MEM_SIZE_BITS-1:0] SIZE_MEDIUM_MAX = MEM_SIZE_BITS'(262144);
   localparam logic [MEM_SIZE_BITS-1:0] SIZE_RESET      = MEM_SIZE_BITS'(524288);
   localparam logic [POLL_LIMIT_BITS-1:0] POLL_RESET    = POLL_LIMIT_BITS'(1024);

   // page offset masks for 64, 128 and 256 byte pages
   localparam logic [PAGE_BITS-1:0] PAGE_MASK_64  = PAGE_BITS'(64 - 1);
   localparam logic [PAGE_BITS-1:0] PAGE_MASK_128 = PAGE_BITS'(128 - 1);
   localparam logic [PAGE_BITS-1:0] PAGE_MASK_256 = PAGE_BITS'(256 - 1);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_MEMORY_SIZE = 2'd0,
      REG_POLL_LIMIT  = 2'd1
   } reg_index_type;

   typedef enum logic {
      CMD_PROGRAM = 1'b0,
      CMD_POLL    = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      ACT_UNLOCK  = 3'd0,
      ACT_WRITE   = 3'd1,
      ACT_VERIFY  = 3'd2,
      ACT_OK      = 3'd3,
      ACT_TIMEOUT = 3'd4,
      ACT_IGNORED = 3'd5,
      ACT_DONE    = 3'd6
   } action_type;

   // up to three results per input item; last_idx selects the final one
   typedef struct packed {
      action_type  act0;
      action_type  act1;
      action_type  act2;
      logic [1:0]  last_idx;
   } job_ctrl_type;

endpackage

/* design/fpps_if.sv */
// ----------------------------------------------------------------------------
// Flash page program sequencer channels
// Valid/ready channels for write and poll items, results and register writes.
// ----------------------------------------------------------------------------
interface fpps_req_if #(parameter int ADDRESS_BITS = fpps_pkg::ADDRESS_BITS_DEFAULT);
   logic                    valid;
   logic                    ready;
   logic                    command;
   logic [ADDRESS_BITS-1:0] byte_address;
   logic [7:0]              write_data;
   logic                    final_byte;
   logic [7:0]              read_back;

   modport source (output valid, command, byte_address, write_data, final_byte, read_back,
                   input ready);
   modport sink (input valid, command, byte_address, write_data, final_byte, read_back,
                 output ready);
endinterface

interface fpps_rsp_if #(parameter int ADDRESS_BITS = fpps_pkg::ADDRESS_BITS_DEFAULT);
   logic                    valid;
   logic                    ready;
   logic [2:0]              action;
   logic [ADDRESS_BITS-1:0] out_address;
   logic [7:0]              out_data;
   logic [7:0]              observed;
   logic                    run_last;

   modport source (output valid, action, out_address, out_data, observed, run_last,
                   input ready);
   modport sink (input valid, action, out_address, out_data, observed, run_last,
                 output ready);
endinterface

interface fpps_csr_if;
   logic                                valid;
   logic                                ready;
   logic [fpps_pkg::CSR_INDEX_BITS-1:0] index;
   logic [fpps_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* design/flash_page_program_sequencer_core.sv */
// ----------------------------------------------------------------------------
// Flash page program sequencer core
// Page-mode programming with protection unlock and data-polling verify.
//
//   channel  direction  carries
//   req_ch   in         write byte or verify read result
//   rsp_ch   out        unlock, write, verify, ok, timeout, ignored, done
//   csr_ch   in         memory_size (index 0), poll_limit (index 1)
//
// An item is classified in the cycle it is accepted and enters a two-entry
// queue; the expander sends one result per cycle while the result port is
// not stalled, and an item yields one to three results.
// Items with a single result flow at one per cycle when the port is not stalled.
// Reset is synchronous; no clearing pass is needed.
// A stalled result port backs up through the queue to req_ch.ready.
// ----------------------------------------------------------------------------
module flash_page_program_sequencer_core import fpps_pkg::*; #(
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   fpps_req_if.sink    req_ch,
   fpps_rsp_if.source  rsp_ch,
   fpps_csr_if.sink    csr_ch
);

   localparam int JOB_BITS = $bits(job_ctrl_type) + ADDRESS_BITS + 2 * DATA_BITS;

   logic                    queue_full;
   logic                    queue_empty;
   logic                    job_push;
   logic                    queue_pop;
   job_ctrl_type            push_ctrl;
   logic [ADDRESS_BITS-1:0] push_address;
   logic [DATA_BITS-1:0]    push_data;
   logic [DATA_BITS-1:0]    push_observed;
   logic [JOB_BITS-1:0]     push_job;
   logic [JOB_BITS-1:0]     head_job;
   job_ctrl_type            head_ctrl;
   logic [ADDRESS_BITS-1:0] head_address;
   logic [DATA_BITS-1:0]    head_data;
   logic [DATA_BITS-1:0]    head_observed;

   assign push_job = {push_ctrl, push_address, push_data, push_observed};
   assign {head_ctrl, head_address, head_data, head_observed} = head_job;

   fpps_front #(
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .csr_ch       (csr_ch),
      .queue_full   (queue_full),
      .job_push     (job_push),
      .job_ctrl     (push_ctrl),
      .job_address  (push_address),
      .job_data     (push_data),
      .job_observed (push_observed)
   );

   fpps_fifo #(
      .WIDTH (JOB_BITS)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .full      (queue_full),
      .pop       (queue_pop),
      .empty     (queue_empty),
      .head_data (head_job)
   );

   fpps_back #(
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_empty  (queue_empty),
      .queue_pop    (queue_pop),
      .job_ctrl     (head_ctrl),
      .job_address  (head_address),
      .job_data     (head_data),
      .job_observed (head_observed),
      .rsp_ch       (rsp_ch)
   );

endmodule

/* design/fpps_fifo.sv */
// ----------------------------------------------------------------------------
// Two-entry job queue
// Holds classified jobs between the front end and the result expander.
// ----------------------------------------------------------------------------
module fpps_fifo import fpps_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] head_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop) else $error("job queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("job queue underflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("job queue count out of range");
`endif

endmodule

/* design/fpps_front.sv */
// ----------------------------------------------------------------------------
// Front end
// Holds the registers and sequencing state, classifies each item and turns
// it into a job of one to three results.
// ----------------------------------------------------------------------------
module fpps_front import fpps_pkg::*; #(
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   fpps_req_if.sink                req_ch,
   fpps_csr_if.sink                csr_ch,
   input  logic                    queue_full,
   output logic                    job_push,
   output job_ctrl_type            job_ctrl,
   output logic [ADDRESS_BITS-1:0] job_address,
   output logic [DATA_BITS-1:0]    job_data,
   output logic [DATA_BITS-1:0]    job_observed
);

   logic [MEM_SIZE_BITS-1:0]   mem_size_ff;
   logic [POLL_LIMIT_BITS-1:0] poll_limit_ff;

   logic                       pending_ff, pending_in;
   logic [ADDRESS_BITS-1:0]    paddr_ff, paddr_in;
   logic [DATA_BITS-1:0]       pexp_ff, pexp_in;
   logic                       pfinal_ff, pfinal_in;
   logic [POLL_LIMIT_BITS-1:0] count_ff, count_in;
   logic                       at_start_ff, at_start_in;
   logic                       aborted_ff, aborted_in;

   logic                       accept;
   logic [PAGE_BITS-1:0]       page_mask;
   logic [PAGE_BITS-1:0]       offset;
   logic                       page_start, page_end, lead, close;
   logic [POLL_LIMIT_BITS-1:0] limit;

   assign req_ch.ready = !queue_full;
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && !queue_full;
   assign job_push     = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_size_ff   <= SIZE_RESET;
         poll_limit_ff <= POLL_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_MEMORY_SIZE: mem_size_ff   <= csr_ch.data;
            REG_POLL_LIMIT:  poll_limit_ff <= csr_ch.data[POLL_LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (mem_size_ff <= SIZE_SMALL_MAX) begin
         page_mask = PAGE_MASK_64;
      end else if (mem_size_ff <= SIZE_MEDIUM_MAX) begin
         page_mask = PAGE_MASK_128;
      end else begin
         page_mask = PAGE_MASK_256;
      end
      offset     = req_ch.byte_address[PAGE_BITS-1:0] & page_mask;
      page_start = (offset == '0);
      page_end   = (offset == page_mask);
      lead       = page_start || at_start_ff;
      close      = page_end || req_ch.final_byte;
      // a limit of zero behaves as one
      limit      = (poll_limit_ff == '0) ? POLL_LIMIT_BITS'(1) : poll_limit_ff;
   end

   always_comb begin
      pending_in   = pending_ff;
      paddr_in     = paddr_ff;
      pexp_in      = pexp_ff;
      pfinal_in    = pfinal_ff;
      count_in     = count_ff;
      at_start_in  = at_start_ff;
      aborted_in   = aborted_ff;
      job_ctrl     = '{act0: ACT_IGNORED, act1: ACT_IGNORED, act2: ACT_IGNORED,
                       last_idx: 2'd0};
      job_address  = paddr_ff;
      job_data     = pexp_ff;
      job_observed = '0;

      if (req_ch.command == CMD_PROGRAM) begin
         if (aborted_ff) begin
            // drop writes up to the final one of the transfer
            if (req_ch.final_byte) begin
               aborted_in  = 1'b0;
               at_start_in = 1'b1;
            end
         end else if (!pending_ff) begin
            job_address = req_ch.byte_address;
            job_data    = req_ch.write_data;
            if (lead) begin
               job_ctrl.act0     = ACT_UNLOCK;
               job_ctrl.act1     = ACT_WRITE;
               job_ctrl.act2     = ACT_VERIFY;
               job_ctrl.last_idx = close ? 2'd2 : 2'd1;
            end else begin
               job_ctrl.act0     = ACT_WRITE;
               job_ctrl.act1     = ACT_VERIFY;
               job_ctrl.last_idx = close ? 2'd1 : 2'd0;
            end
            at_start_in = 1'b0;
            if (close) begin
               pending_in = 1'b1;
               paddr_in   = req_ch.byte_address;
               pexp_in    = req_ch.write_data;
               pfinal_in  = req_ch.final_byte;
               count_in   = POLL_LIMIT_BITS'(1);
            end
         end
      end else if (pending_ff) begin
         if (req_ch.read_back == pexp_ff) begin
            job_ctrl.act0     = ACT_OK;
            job_ctrl.act1     = ACT_DONE;
            job_ctrl.last_idx = pfinal_ff ? 2'd1 : 2'd0;
            pending_in        = 1'b0;
            if (pfinal_ff) begin
               at_start_in = 1'b1;
            end
         end else if (count_ff < limit) begin
            job_ctrl.act0 = ACT_VERIFY;
            count_in      = count_ff + POLL_LIMIT_BITS'(1);
         end else begin
            job_ctrl.act0 = ACT_TIMEOUT;
            job_observed  = req_ch.read_back;
            pending_in    = 1'b0;
            if (pfinal_ff) begin
               at_start_in = 1'b1;
            end else begin
               aborted_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= 1'b0;
         pfinal_ff   <= 1'b0;
         count_ff    <= '0;
         at_start_ff <= 1'b1;
         aborted_ff  <= 1'b0;
      end else if (accept) begin
         pending_ff  <= pending_in;
         pfinal_ff   <= pfinal_in;
         count_ff    <= count_in;
         at_start_ff <= at_start_in;
         aborted_ff  <= aborted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         paddr_ff <= paddr_in;
         pexp_ff  <= pexp_in;
      end
   end

`ifndef SYNTH
   a_abort_excludes_poll: assert property (@(posedge clock) disable iff (reset)
      !(aborted_ff && pending_ff)) else $error("aborted while a verify is pending");
   a_abort_excludes_start: assert property (@(posedge clock) disable iff (reset)
      !(aborted_ff && at_start_ff)) else $error("aborted at transfer start");
   a_poll_excludes_start: assert property (@(posedge clock) disable iff (reset)
      !(pending_ff && at_start_ff)) else $error("verify pending at transfer start");
`endif

endmodule

/* design/fpps_back.sv */
// ----------------------------------------------------------------------------
// Result expander
// Walks the head job of the queue one result at a time into the output
// register.
// ----------------------------------------------------------------------------
module fpps_back import fpps_pkg::*; #(
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    queue_empty,
   output logic                    queue_pop,
   input  job_ctrl_type            job_ctrl,
   input  logic [ADDRESS_BITS-1:0] job_address,
   input  logic [DATA_BITS-1:0]    job_data,
   input  logic [DATA_BITS-1:0]    job_observed,
   fpps_rsp_if.source              rsp_ch
);

   logic                    valid_ff, valid_in;
   action_type              action_ff, action_in;
   logic [ADDRESS_BITS-1:0] address_ff, address_in;
   logic [DATA_BITS-1:0]    data_ff, data_in;
   logic [DATA_BITS-1:0]    observed_ff, observed_in;
   logic                    last_ff, last_in;
   logic [1:0]              idx_ff, idx_in;

   logic                    load;
   logic                    is_last;
   action_type              cur_act;

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.action      = 3'(action_ff);
   assign rsp_ch.out_address = address_ff;
   assign rsp_ch.out_data    = data_ff;
   assign rsp_ch.observed    = observed_ff;
   assign rsp_ch.run_last    = last_ff;

   always_comb begin
      case (idx_ff)
         2'd0:    cur_act = job_ctrl.act0;
         2'd1:    cur_act = job_ctrl.act1;
         default: cur_act = job_ctrl.act2;
      endcase
      is_last   = (idx_ff == job_ctrl.last_idx);
      load      = !queue_empty && (!valid_ff || rsp_ch.ready);
      queue_pop = load && is_last;

      idx_in      = idx_ff;
      valid_in    = valid_ff && !rsp_ch.ready;
      action_in   = action_ff;
      address_in  = address_ff;
      data_in     = data_ff;
      observed_in = observed_ff;
      last_in     = last_ff;
      if (load) begin
         idx_in    = is_last ? 2'd0 : idx_ff + 2'd1;
         valid_in  = 1'b1;
         action_in = cur_act;
         last_in   = is_last;
         if (cur_act inside {ACT_WRITE, ACT_VERIFY, ACT_OK, ACT_TIMEOUT}) begin
            address_in = job_address;
            data_in    = job_data;
         end else begin
            address_in = '0;
            data_in    = '0;
         end
         observed_in = (cur_act == ACT_TIMEOUT) ? job_observed : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      address_ff  <= address_in;
      data_ff     <= data_in;
      observed_ff <= observed_in;
      last_ff     <= last_in;
   end

`ifndef SYNTH
   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      !queue_empty |-> idx_ff <= job_ctrl.last_idx) else $error("result index past job");
   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      queue_empty |-> idx_ff == 2'd0) else $error("result index left over");
   a_unlock_not_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && action_ff == ACT_UNLOCK |-> !last_ff) else $error("unlock closes an item");
`endif

endmodule

/* test/flash_page_program_sequencer_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flash page program sequencer core testbench
// Drives write and poll items through valid/ready channels at random rates,
// predicts unlock, write, verify, ok, timeout, ignored and done results per
// item, and checks every result in order. Page size and poll limit are swept
// through several settings between phases, extremes included.
// ----------------------------------------------------------------------------
module flash_page_program_sequencer_core_test;
   import fpps_pkg::*;

   localparam int ADDR_W = ADDRESS_BITS_DEFAULT;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned DRAIN_CYCLES = 8;

   typedef struct packed {
      command_type       command;
      logic [ADDR_W-1:0] byte_address;
      logic [7:0]        write_data;
      logic              final_byte;
      logic [7:0]        read_back;
   } flash_request_t;

   typedef struct packed {
      action_type        action;
      logic [ADDR_W-1:0] out_address;
      logic [7:0]        out_data;
      logic [7:0]        observed;
      logic              run_last;
   } flash_result_t;

   class page_program_scoreboard;
      int unsigned errors = 0;
      flash_result_t awaited_actions[$];
      flash_result_t burst[$];
      logic [MEM_SIZE_BITS-1:0]   memory_size = SIZE_RESET;
      logic [POLL_LIMIT_BITS-1:0] poll_limit = POLL_RESET;
      logic [POLL_LIMIT_BITS-1:0] poll_count = '0;
      logic [ADDR_W-1:0]          pending_address = '0;
      logic [7:0]                 pending_expected = '0;
      bit poll_pending = 1'b0;
      bit pending_final = 1'b0;
      bit transfer_start = 1'b1;
      bit aborted = 1'b0;

      function void set_register(reg_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            REG_MEMORY_SIZE: memory_size = value[MEM_SIZE_BITS-1:0];
            REG_POLL_LIMIT:  poll_limit = value[POLL_LIMIT_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [PAGE_BITS-1:0] page_mask();
         if (memory_size <= SIZE_SMALL_MAX) return PAGE_MASK_64;
         if (memory_size <= SIZE_MEDIUM_MAX) return PAGE_MASK_128;
         return PAGE_MASK_256;
      endfunction

      function int unsigned effective_limit();
         return (poll_limit == '0) ? 1 : poll_limit;
      endfunction

      function int unsigned outstanding();
         return awaited_actions.size();
      endfunction

      function void emit(action_type act, logic [ADDR_W-1:0] addr, logic [7:0] data,
                         logic [7:0] seen);
         flash_result_t r;
         r.action = act;
         r.out_address = addr;
         r.out_data = data;
         r.observed = seen;
         r.run_last = 1'b0;
         burst.push_back(r);
      endfunction

      // work out the results of one accepted item and queue them
      function void note_request(flash_request_t rq);
         logic [PAGE_BITS-1:0] mask;
         logic [PAGE_BITS-1:0] offset;
         bit page_start;
         bit page_end;
         mask = page_mask();
         offset = rq.byte_address[PAGE_BITS-1:0];
         page_start = (offset & mask) == '0;
         page_end = ((offset + 1'b1) & mask) == '0;
         if (rq.command == CMD_PROGRAM) begin
            if (aborted) begin
               emit(ACT_IGNORED, '0, '0, '0);
               if (rq.final_byte) begin
                  aborted = 1'b0;
                  transfer_start = 1'b1;
               end
            end else if (poll_pending) begin
               emit(ACT_IGNORED, '0, '0, '0);
            end else begin
               if (page_start || transfer_start) emit(ACT_UNLOCK, '0, '0, '0);
               emit(ACT_WRITE, rq.byte_address, rq.write_data, '0);
               transfer_start = 1'b0;
               if (page_end || rq.final_byte) begin
                  emit(ACT_VERIFY, rq.byte_address, rq.write_data, '0);
                  poll_pending = 1'b1;
                  pending_address = rq.byte_address;
                  pending_expected = rq.write_data;
                  pending_final = rq.final_byte;
                  poll_count = POLL_LIMIT_BITS'(1);
               end
            end
         end else if (!poll_pending) begin
            emit(ACT_IGNORED, '0, '0, '0);
         end else if (rq.read_back == pending_expected) begin
            emit(ACT_OK, pending_address, pending_expected, '0);
            poll_pending = 1'b0;
            if (pending_final) begin
               emit(ACT_DONE, '0, '0, '0);
               transfer_start = 1'b1;
            end
         end else if (poll_count < effective_limit()) begin
            poll_count = poll_count + 1'b1;
            emit(ACT_VERIFY, pending_address, pending_expected, '0);
         end else begin
            emit(ACT_TIMEOUT, pending_address, pending_expected, rq.read_back);
            poll_pending = 1'b0;
            if (pending_final) transfer_start = 1'b1;
            else aborted = 1'b1;
         end
         burst[burst.size() - 1].run_last = 1'b1;
         foreach (burst[i]) awaited_actions.push_back(burst[i]);
         burst.delete();
      endfunction

      function void check_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
         end
      endfunction

      function void check_result(flash_result_t got);
         flash_result_t want;
         if (awaited_actions.size() == 0) begin
            errors++;
            $display("%0t: result expected none, actual action %0d address %h data %h",
                     $time, got.action, got.out_address, got.out_data);
            return;
         end
         want = awaited_actions.pop_front();
         check_field("action", 32'(want.action), 32'(got.action));
         check_field("out_address", 32'(want.out_address), 32'(got.out_address));
         check_field("out_data", 32'(want.out_data), 32'(got.out_data));
         check_field("observed", 32'(want.observed), 32'(got.observed));
         check_field("run_last", 32'(want.run_last), 32'(got.run_last));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   fpps_req_if req_ch ();
   fpps_rsp_if rsp_ch ();
   fpps_csr_if csr_ch ();

   flash_page_program_sequencer_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   page_program_scoreboard board = new;

   int unsigned items_offered = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_off_cycles = 0;
   bit steady = 1'b0;
   flash_request_t seen_request;
   flash_result_t seen_result;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seen_request.command = command_type'(req_ch.command);
            seen_request.byte_address = req_ch.byte_address;
            seen_request.write_data = req_ch.write_data;
            seen_request.final_byte = req_ch.final_byte;
            seen_request.read_back = req_ch.read_back;
            board.note_request(seen_request);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_result.action = action_type'(rsp_ch.action);
            seen_result.out_address = rsp_ch.out_address;
            seen_result.out_data = rsp_ch.out_data;
            seen_result.observed = rsp_ch.observed;
            seen_result.run_last = rsp_ch.run_last;
            board.check_result(seen_result);
         end
      end
   end

   // result side: random stalls, or a long hold-off when asked for
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end
         rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 32);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [ADDR_W-1:0] any_address();
      return ADDR_W'($urandom());
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom());
   endfunction

   task automatic offer(input command_type cmd, input logic [ADDR_W-1:0] addr,
                        input logic [7:0] data, input logic fin, input logic [7:0] rb);
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.byte_address <= addr;
      req_ch.write_data <= data;
      req_ch.final_byte <= fin;
      req_ch.read_back <= rb;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_offered++;
      if (!steady && $urandom_range(0, 99) < 32) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   task automatic send_write(input logic [ADDR_W-1:0] addr, input logic [7:0] data,
                             input logic fin);
      offer(CMD_PROGRAM, addr, data, fin, any_byte());
   endtask

   task automatic send_poll(input logic [7:0] rb);
      offer(CMD_POLL, any_address(), any_byte(), 1'($urandom()), rb);
   endtask

   // hold the request side idle until every result is in, then let it settle
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [CSR_DATA_BITS-1:0] size,
                                 input logic [CSR_DATA_BITS-1:0] limit);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= REG_MEMORY_SIZE;
      csr_ch.data <= size;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      board.set_register(REG_MEMORY_SIZE, size);
      csr_ch.index <= REG_POLL_LIMIT;
      csr_ch.data <= limit;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      board.set_register(REG_POLL_LIMIT, limit);
      csr_ch.valid <= 1'b0;
   endtask

   // poll until the byte matches, or run the page out to a timeout
   task automatic answer_polls(input logic [7:0] expected);
      int unsigned lim;
      int unsigned misses;
      int unsigned k;
      lim = board.effective_limit();
      if ($urandom_range(0, 9) == 0) send_write(any_address(), any_byte(), 1'($urandom()));
      if (lim <= 8 && $urandom_range(0, 99) < 25) misses = lim;
      else misses = $urandom_range(0, (lim - 1 < 3) ? lim - 1 : 3);
      for (k = 0; k < misses; k++) send_poll(expected ^ 8'($urandom_range(1, 255)));
      if (misses < lim) send_poll(expected);
   endtask

   task automatic run_transfers(input int unsigned budget);
      int unsigned stop_at;
      int unsigned length;
      int unsigned i;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] addr;
      logic [7:0] data;
      stop_at = items_offered + budget;
      while (items_offered < stop_at) begin
         if ($urandom_range(0, 99) < 15) begin
            offer(command_type'($urandom_range(0, 1)), any_address(), any_byte(),
                  1'($urandom()), any_byte());
         end else begin
            mask = ADDR_W'(board.page_mask());
            length = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40)
                                                 : $urandom_range(1, 8);
            case ($urandom_range(0, 3))
               0: start = any_address() & ~mask;
               1: start = (any_address() | mask) - ADDR_W'($urandom_range(0, 3));
               2: start = ~ADDR_W'($urandom_range(0, 5));
               default: start = any_address();
            endcase
            for (i = 0; i < length; i++) begin
               addr = start + ADDR_W'(i);
               data = any_byte();
               send_write(addr, data, i == length - 1);
               if ((((addr + 1'b1) & mask) == '0) || i == length - 1) answer_polls(data);
            end
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.command <= CMD_PROGRAM;
      req_ch.byte_address <= '0;
      req_ch.write_data <= '0;
      req_ch.final_byte <= 1'b0;
      req_ch.read_back <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= REG_MEMORY_SIZE;
      csr_ch.data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // 256 byte pages, reset poll limit
      send_poll(8'h00);
      send_write('0, 8'h00, 1'b0);
      send_write(ADDR_W'(1), 8'hFF, 1'b0);
      send_write(ADDR_W'(8'hFF), 8'hA5, 1'b0);
      send_write(ADDR_W'(2), 8'h11, 1'b0);
      send_poll(8'h00);
      send_poll(8'hFF);
      send_poll(8'hA5);
      send_write('1, 8'h5A, 1'b1);
      send_poll(8'hFF);
      send_poll(8'h5A);
      send_write(ADDR_W'(16'h0100), 8'h77, 1'b0);
      settle();

      // single poll: time out mid-transfer, then on the final page
      apply_settings(SIZE_RESET, 1);
      send_write(ADDR_W'(16'h03FF), 8'h3C, 1'b0);
      send_poll(8'hC3);
      send_write(ADDR_W'(16'h0400), 8'h01, 1'b0);
      send_write(ADDR_W'(16'h0401), 8'h02, 1'b1);
      send_write(ADDR_W'(8'h12), 8'h80, 1'b1);
      send_poll(8'h7F);
      send_write(ADDR_W'(8'h55), 8'h0F, 1'b0);
      send_poll(8'h0F);
      settle();

      apply_settings(0, 0);
      run_transfers(6);
      settle();

      apply_settings(65536, 2);
      run_transfers(6);
      settle();

      // block the result side so the input backs up
      apply_settings(65537, 3);
      hold_off_cycles = 120;
      run_transfers(6);
      settle();

      steady = 1'b1;
      apply_settings(262144, 1);
      run_transfers(6);
      settle();
      steady = 1'b0;

      apply_settings(262145, 2047);
      run_transfers(6);
      settle();

      apply_settings(20'hFFFFF, 4);
      run_transfers(6);
      settle();

      if (board.errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* sim.f */
design/fpps_pkg.sv
design/fpps_if.sv
design/fpps_fifo.sv
design/fpps_front.sv
design/fpps_back.sv
design/flash_page_program_sequencer_core.sv
test/flash_page_program_sequencer_core_test.sv
